@@ design/length_bucketed_batch_former_macros.svh @@
// Assertion helpers used by the engine RTL.
`ifndef LENGTH_BUCKETED_BATCH_FORMER_MACROS_SVH
`define LENGTH_BUCKETED_BATCH_FORMER_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted.
`define LBBF_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define LBBF_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/lbbf_pkg.sv @@
package lbbf_pkg;

	localparam int ID_W    = 16;
	localparam int LEN_W   = 7;
	localparam int BUDGET_W = 16;

	// command selector on the input side
	localparam logic CMD_OP_ADD = 1'b0;
	localparam logic CMD_OP_CUT = 1'b1;

	// register indexes (paddr[2])
	localparam logic REG_BUDGET  = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	localparam logic [BUDGET_W-1:0] BUDGET_RST  = 16'd1024;
	localparam logic [LEN_W-1:0]    MAX_LEN_RST = 7'd64;

	// command queue between front and engine
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_CUT,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_FULL     = 3'd1,
		ST_MEMBER   = 3'd2,
		ST_NO_BATCH = 3'd3,
		ST_REJECT   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		EN_IDLE,
		EN_ADD_WR,
		EN_REJECT,
		EN_CUT_RD,
		EN_CUT_CHK,
		EN_CUT_TAKE,
		EN_CUT_EMIT,
		EN_CUT_DONE
	} eng_state_t;

endpackage

@@ design/lbbf_front.sv @@
module lbbf_front #(
	parameter int MAX_LENGTH = 64
) (
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [23:0]                 s_axis_tdata,  // sentence_id, token_count, pad
	input  logic                        s_axis_tuser,  // cmd
	input  logic [lbbf_pkg::LEN_W-1:0]  max_len,
	output logic                        push_valid,
	input  logic                        push_ready,
	output lbbf_pkg::cmd_t              push_cmd
);

	logic [lbbf_pkg::LEN_W-1:0] len;
	logic                       too_long;

	assign len      = s_axis_tdata[lbbf_pkg::ID_W +: lbbf_pkg::LEN_W];
	assign too_long = (len > max_len) || (int'(len) > MAX_LENGTH);

	assign push_valid    = s_axis_tvalid;
	assign s_axis_tready = push_ready;

	always_comb begin
		push_cmd.id  = s_axis_tdata[lbbf_pkg::ID_W-1:0];
		push_cmd.len = len;
		unique case (s_axis_tuser)
			lbbf_pkg::CMD_OP_CUT: push_cmd.kind = lbbf_pkg::CMD_CUT;
			default:              push_cmd.kind = too_long ? lbbf_pkg::CMD_REJECT
				                                             : lbbf_pkg::CMD_ADD;
		endcase
	end

endmodule

@@ design/lbbf_queue.sv @@
module lbbf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  lbbf_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output lbbf_pkg::cmd_t pop_cmd
);

	lbbf_pkg::cmd_t                  slots_q [lbbf_pkg::CQ_DEPTH];
	logic [lbbf_pkg::CQ_PW-1:0]      wr_ptr_q;
	logic [lbbf_pkg::CQ_PW-1:0]      rd_ptr_q;
	logic [lbbf_pkg::CQ_CW-1:0]      cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = cnt_q != lbbf_pkg::CQ_CW'(lbbf_pkg::CQ_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slots_q[wr_ptr_q] <= push_cmd;
	end

endmodule

@@ design/lbbf_engine.sv @@
`include "length_bucketed_batch_former_macros.svh"

module lbbf_engine #(
	parameter int MAX_LENGTH  = 64,
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_BATCH   = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  lbbf_pkg::cmd_t                 cmd,
	input  logic [lbbf_pkg::BUDGET_W-1:0]  budget,
	output logic                           out_valid,
	input  logic                           out_ready,
	output lbbf_pkg::status_t              out_status,
	output logic [lbbf_pkg::ID_W-1:0]      out_id,
	output logic [lbbf_pkg::LEN_W-1:0]     out_length,
	output logic                           out_last
);

	localparam int NB   = MAX_LENGTH + 1;
	localparam int BKW  = $clog2(NB);
	localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW   = $clog2(QUEUE_DEPTH + 1);
	localparam int SW   = HW + 1;
	localparam int MW   = HW + FW;
	localparam int AW   = $clog2(NB * QUEUE_DEPTH);
	localparam int CW   = $clog2(MAX_BATCH + 1);
	localparam int PW   = CW + BKW;
	localparam int CMPW = (PW > lbbf_pkg::BUDGET_W) ? PW : lbbf_pkg::BUDGET_W;

	lbbf_pkg::eng_state_t state_q, state_d;

	// bucket bookkeeping: {head, fill} per length, valid bit marks written rows
	logic [MW-1:0]                 meta_mem [NB];
	logic [NB-1:0]                 meta_vld_q;
	logic [MW-1:0]                 meta_rd_q;
	logic                          meta_rvld_q;
	logic [lbbf_pkg::ID_W-1:0]     store_mem [NB * QUEUE_DEPTH];
	logic [lbbf_pkg::ID_W-1:0]     store_rd_q;

	lbbf_pkg::cmd_t                cmd_q;
	logic [BKW-1:0]                bkt_q;
	logic [CW-1:0]                 count_q;
	logic [HW-1:0]                 cur_head_q;
	logic [FW-1:0]                 cur_fill_q;
	logic                          pend_vld_q;
	logic [lbbf_pkg::ID_W-1:0]     pend_id_q;
	logic [lbbf_pkg::LEN_W-1:0]    pend_len_q;

	logic                          out_vld_q;
	lbbf_pkg::status_t             out_status_q;
	logic [lbbf_pkg::ID_W-1:0]     out_id_q;
	logic [lbbf_pkg::LEN_W-1:0]    out_len_q;
	logic                          out_last_q;

	// helpers
	logic                          out_free;
	logic [BKW-1:0]                add_bkt;
	logic [HW-1:0]                 rd_head;
	logic [FW-1:0]                 rd_fill;
	logic                          add_full;
	logic [SW-1:0]                 slot_sum;
	logic [HW-1:0]                 add_slot;
	logic [PW-1:0]                 padded;
	logic                          batch_stop;
	logic                          cur_empty;
	logic                          bkt_end;
	logic                          emit_ok;
	logic [HW-1:0]                 head_next;

	// control
	logic                          meta_re;
	logic [BKW-1:0]                meta_raddr;
	logic                          meta_we;
	logic [BKW-1:0]                meta_waddr;
	logic [MW-1:0]                 meta_wdata;
	logic                          store_re;
	logic [AW-1:0]                 store_raddr;
	logic                          store_we;
	logic [AW-1:0]                 store_waddr;
	logic                          out_load;
	lbbf_pkg::status_t             out_status_d;
	logic [lbbf_pkg::ID_W-1:0]     out_id_d;
	logic [lbbf_pkg::LEN_W-1:0]    out_len_d;
	logic                          out_last_d;
	logic                          cut_start;
	logic                          bkt_inc;
	logic                          cur_load;
	logic                          take;
	logic                          pend_load;
	logic                          pend_clr;

	assign out_free = !out_vld_q || out_ready;
	assign add_bkt  = BKW'(cmd_q.len);
	assign rd_head  = meta_rvld_q ? meta_rd_q[MW-1:FW] : '0;
	assign rd_fill  = meta_rvld_q ? meta_rd_q[FW-1:0] : '0;
	assign add_full = rd_fill == FW'(QUEUE_DEPTH);
	assign slot_sum = SW'(rd_head) + SW'(rd_fill);
	assign add_slot = (slot_sum >= SW'(QUEUE_DEPTH)) ? HW'(slot_sum - SW'(QUEUE_DEPTH))
	                                                 : HW'(slot_sum);
	assign padded     = (PW'(count_q) + PW'(1)) * PW'(bkt_q);
	assign batch_stop = (count_q == CW'(MAX_BATCH)) || (CMPW'(padded) > CMPW'(budget));
	assign cur_empty  = cur_fill_q == '0;
	assign bkt_end    = bkt_q == BKW'(MAX_LENGTH);
	assign emit_ok    = !pend_vld_q || out_free;
	assign head_next  = (cur_head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : cur_head_q + 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lbbf_pkg::EN_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						lbbf_pkg::CMD_ADD: state_d = lbbf_pkg::EN_ADD_WR;
						lbbf_pkg::CMD_CUT: state_d = lbbf_pkg::EN_CUT_RD;
						default:           state_d = lbbf_pkg::EN_REJECT;
					endcase
				end
			end
			lbbf_pkg::EN_ADD_WR,
			lbbf_pkg::EN_REJECT,
			lbbf_pkg::EN_CUT_DONE: begin
				if (out_free) state_d = lbbf_pkg::EN_IDLE;
			end
			lbbf_pkg::EN_CUT_RD:  state_d = lbbf_pkg::EN_CUT_CHK;
			lbbf_pkg::EN_CUT_CHK: state_d = lbbf_pkg::EN_CUT_TAKE;
			lbbf_pkg::EN_CUT_TAKE: begin
				if (cur_empty)       state_d = bkt_end ? lbbf_pkg::EN_CUT_DONE : lbbf_pkg::EN_CUT_RD;
				else if (batch_stop) state_d = lbbf_pkg::EN_CUT_DONE;
				else                 state_d = lbbf_pkg::EN_CUT_EMIT;
			end
			lbbf_pkg::EN_CUT_EMIT: begin
				if (emit_ok) state_d = lbbf_pkg::EN_CUT_TAKE;
			end
			default: state_d = lbbf_pkg::EN_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready    = 1'b0;
		meta_re      = 1'b0;
		meta_raddr   = bkt_q;
		meta_we      = 1'b0;
		meta_waddr   = bkt_q;
		meta_wdata   = {cur_head_q, cur_fill_q};
		store_re     = 1'b0;
		store_raddr  = AW'(bkt_q) * AW'(QUEUE_DEPTH) + AW'(cur_head_q);
		store_we     = 1'b0;
		store_waddr  = AW'(add_bkt) * AW'(QUEUE_DEPTH) + AW'(add_slot);
		out_load     = 1'b0;
		out_status_d = lbbf_pkg::ST_ADDED;
		out_id_d     = '0;
		out_len_d    = '0;
		out_last_d   = 1'b1;
		cut_start    = 1'b0;
		bkt_inc      = 1'b0;
		cur_load     = 1'b0;
		take         = 1'b0;
		pend_load    = 1'b0;
		pend_clr     = 1'b0;
		unique case (state_q)
			lbbf_pkg::EN_IDLE: begin
				cmd_ready  = 1'b1;
				meta_raddr = BKW'(cmd.len);
				meta_re    = cmd_valid && (cmd.kind == lbbf_pkg::CMD_ADD);
				cut_start  = cmd_valid && (cmd.kind == lbbf_pkg::CMD_CUT);
			end
			lbbf_pkg::EN_ADD_WR: begin
				meta_waddr = add_bkt;
				meta_wdata = {rd_head, rd_fill + 1'b1};
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = add_full ? lbbf_pkg::ST_FULL : lbbf_pkg::ST_ADDED;
					store_we     = !add_full;
					meta_we      = !add_full;
				end
			end
			lbbf_pkg::EN_REJECT: begin
				out_load     = out_free;
				out_status_d = lbbf_pkg::ST_REJECT;
			end
			lbbf_pkg::EN_CUT_RD: begin
				meta_re = 1'b1;
			end
			lbbf_pkg::EN_CUT_CHK: begin
				cur_load = 1'b1;
			end
			lbbf_pkg::EN_CUT_TAKE: begin
				if (cur_empty) begin
					meta_we = 1'b1;
					bkt_inc = !bkt_end;
				end else if (batch_stop) begin
					meta_we = 1'b1;
				end else begin
					store_re = 1'b1;
					take     = 1'b1;
				end
			end
			lbbf_pkg::EN_CUT_EMIT: begin
				// hand the previous member on; the new one waits to learn if it is last
				if (emit_ok) begin
					pend_load    = 1'b1;
					out_load     = pend_vld_q;
					out_status_d = lbbf_pkg::ST_MEMBER;
					out_id_d     = pend_id_q;
					out_len_d    = pend_len_q;
					out_last_d   = 1'b0;
				end
			end
			lbbf_pkg::EN_CUT_DONE: begin
				if (out_free) begin
					out_load     = 1'b1;
					pend_clr     = 1'b1;
					out_status_d = pend_vld_q ? lbbf_pkg::ST_MEMBER : lbbf_pkg::ST_NO_BATCH;
					out_id_d     = pend_vld_q ? pend_id_q : '0;
					out_len_d    = pend_vld_q ? pend_len_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lbbf_pkg::EN_IDLE;
			meta_vld_q <= '0;
			bkt_q      <= '0;
			count_q    <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (meta_we) meta_vld_q[meta_waddr] <= 1'b1;
			if (cut_start) begin
				bkt_q   <= '0;
				count_q <= '0;
			end else begin
				if (bkt_inc) bkt_q <= bkt_q + 1'b1;
				if (take)    count_q <= count_q + 1'b1;
			end
			if (pend_clr)       pend_vld_q <= 1'b0;
			else if (pend_load) pend_vld_q <= 1'b1;
			if (out_load)       out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) cmd_q <= cmd;
		if (cur_load) begin
			cur_head_q <= rd_head;
			cur_fill_q <= rd_fill;
		end else if (take) begin
			cur_head_q <= head_next;
			cur_fill_q <= cur_fill_q - 1'b1;
		end
		if (pend_load) begin
			pend_id_q  <= store_rd_q;
			pend_len_q <= lbbf_pkg::LEN_W'(bkt_q);
		end
		if (out_load) begin
			out_status_q <= out_status_d;
			out_id_q     <= out_id_d;
			out_len_q    <= out_len_d;
			out_last_q   <= out_last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
		if (meta_re) begin
			meta_rd_q   <= meta_mem[meta_raddr];
			meta_rvld_q <= meta_vld_q[meta_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) store_mem[store_waddr] <= cmd_q.id;
		if (store_re) store_rd_q <= store_mem[store_raddr];
	end

	assign out_valid  = out_vld_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_length = out_len_q;
	assign out_last   = out_last_q;

	`LBBF_ASSERT_IMP(a_idle_no_pend, clk, arst_n, state_q == lbbf_pkg::EN_IDLE, !pend_vld_q, "member left pending in idle")
	`LBBF_ASSERT_IMP(a_count_cap, clk, arst_n, state_q == lbbf_pkg::EN_CUT_TAKE, count_q <= CW'(MAX_BATCH), "batch count past cap")
	`LBBF_ASSERT_IMP(a_fill_range, clk, arst_n, meta_we, meta_wdata[FW-1:0] <= FW'(QUEUE_DEPTH), "bucket fill overflow")
	`LBBF_ASSERT_NXT(a_take_emits, clk, arst_n, store_re, state_q == lbbf_pkg::EN_CUT_EMIT, "store read without emit step")
	`LBBF_ASSERT_IMP(a_single_last, clk, arst_n, out_vld_q && (out_status_q != lbbf_pkg::ST_MEMBER), out_last_q, "single result without last")

endmodule

@@ design/length_bucketed_batch_former.sv @@
// Add or rejected add: the result is registered once the output is free, and no new request is taken until then.
// Cut: each bucket walked passes CUT_RD, CUT_CHK and CUT_TAKE, and each member taken CUT_TAKE and CUT_EMIT;
// bucket rows are read one at a time from the bookkeeping memory, and the last member is loaded
// in CUT_DONE once the output is free.
// The front queue holds two requests, so input keeps flowing while the engine works, until the queue is full.
// Reset clears control state and marks every bucket empty; the id store is not cleared.
module length_bucketed_batch_former #(
	parameter int MAX_LENGTH  = 64,
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_BATCH   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // sentence_id[15:0], token_count[22:16], zero pad
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // out_id[15:0], out_length[22:16], zero pad
	output logic [2:0]  m_axis_tuser,   // status
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [lbbf_pkg::BUDGET_W-1:0] budget_q;
	logic [lbbf_pkg::LEN_W-1:0]    max_len_q;
	logic                          cfg_wr;

	logic                          push_valid;
	logic                          push_ready;
	lbbf_pkg::cmd_t                push_cmd;
	logic                          pop_valid;
	logic                          pop_ready;
	lbbf_pkg::cmd_t                pop_cmd;

	lbbf_pkg::status_t             out_status;
	logic [lbbf_pkg::ID_W-1:0]     out_id;
	logic [lbbf_pkg::LEN_W-1:0]    out_length;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q  <= lbbf_pkg::BUDGET_RST;
			max_len_q <= lbbf_pkg::MAX_LEN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lbbf_pkg::REG_BUDGET:  budget_q  <= pwdata[lbbf_pkg::BUDGET_W-1:0];
				lbbf_pkg::REG_MAX_LEN: max_len_q <= pwdata[lbbf_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lbbf_pkg::REG_BUDGET:  prdata = {16'd0, budget_q};
			lbbf_pkg::REG_MAX_LEN: prdata = {25'd0, max_len_q};
			default:               prdata = '0;
		endcase
	end

	lbbf_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.max_len      (max_len_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	lbbf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	lbbf_engine #(
		.MAX_LENGTH (MAX_LENGTH),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_BATCH  (MAX_BATCH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.budget    (budget_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_status(out_status),
		.out_id    (out_id),
		.out_length(out_length),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_length, out_id};
	assign m_axis_tuser = out_status;

endmodule

@@ sim/tb_length_bucketed_batch_former.sv @@
module tb_length_bucketed_batch_former;
	import lbbf_pkg::*;

	localparam int TOP_LEN   = 64;
	localparam int SLOTS     = 16;
	localparam int BATCH_CAP = 64;

	typedef struct {
		status_t         status;
		logic [15:0]     id;
		logic [6:0]      len;
		logic            last;
	} batch_result_t;

	typedef enum logic [1:0] {
		ROW_ADD,
		ROW_CUT,
		ROW_CFG
	} row_kind_t;

	// regsel and val are used by register rows; len, reps and val by requests
	typedef struct packed {
		row_kind_t   kind;
		logic        regsel;
		logic [15:0] val;
		logic [6:0]  len;
		logic [4:0]  reps;
		logic        chk;
		status_t     st;
	} plan_row_t;

	localparam int PLAN_ROWS = 22;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{ROW_CUT, 1'b0, 16'h0000, 7'd0,  5'd1,  1'b1, ST_NO_BATCH},
		'{ROW_ADD, 1'b0, 16'h0000, 7'd0,  5'd1,  1'b1, ST_ADDED},
		'{ROW_ADD, 1'b0, 16'hFFFF, 7'd64, 5'd1,  1'b1, ST_ADDED},
		'{ROW_ADD, 1'b0, 16'h1000, 7'd3,  5'd16, 1'b1, ST_ADDED},
		'{ROW_ADD, 1'b0, 16'hBEEF, 7'd3,  5'd1,  1'b1, ST_FULL},
		'{ROW_CUT, 1'b0, 16'h0000, 7'd0,  5'd1,  1'b0, ST_ADDED},
		'{ROW_CUT, 1'b0, 16'h0000, 7'd0,  5'd1,  1'b0, ST_ADDED},
		'{ROW_CUT, 1'b0, 16'h0000, 7'd0,  5'd1,  1'b1, ST_NO_BATCH},
		'{ROW_CFG, REG_MAX_LEN, 16'd10, 7'd0, 5'd0, 1'b0, ST_ADDED},
		'{ROW_ADD, 1'b0, 16'h2A2A, 7'd11, 5'd1,  1'b1, ST_REJECT},
		'{ROW_ADD, 1'b0, 16'h5555, 7'd10, 5'd1,  1'b1, ST_ADDED},
		'{ROW_ADD, 1'b0, 16'h7F00, 7'd64, 5'd1,  1'b1, ST_REJECT},
		'{ROW_CFG, REG_BUDGET, 16'd5, 7'd0, 5'd0, 1'b0, ST_ADDED},
		// shortest queued sentence alone is over budget
		'{ROW_CUT, 1'b0, 16'h0000, 7'd0,  5'd1,  1'b1, ST_NO_BATCH},
		'{ROW_ADD, 1'b0, 16'hAAAA, 7'd2,  5'd1,  1'b1, ST_ADDED},
		'{ROW_CFG, REG_MAX_LEN, 16'd0, 7'd0, 5'd0, 1'b0, ST_ADDED},
		'{ROW_ADD, 1'b0, 16'h00FF, 7'd1,  5'd1,  1'b1, ST_REJECT},
		'{ROW_ADD, 1'b0, 16'h0F0F, 7'd0,  5'd1,  1'b1, ST_ADDED},
		// longer buckets still drain after max_length drops
		'{ROW_CUT, 1'b0, 16'h0000, 7'd0,  5'd1,  1'b0, ST_ADDED},
		'{ROW_CFG, REG_BUDGET, 16'hFFFF, 7'd0, 5'd0, 1'b0, ST_ADDED},
		'{ROW_CFG, REG_MAX_LEN, 16'd64, 7'd0, 5'd0, 1'b0, ST_ADDED},
		'{ROW_CUT, 1'b0, 16'h0000, 7'd0,  5'd1,  1'b0, ST_ADDED}
	};

	localparam int PHASES = 4;
	localparam int PH_BUDGET [PHASES] = '{1, 200, 1024, 64};
	localparam int PH_MAXLEN [PHASES] = '{1, 40, 64, 64};
	localparam int PH_MODE   [PHASES] = '{1, 1, 2, 2};
	localparam int PH_ITEMS  [PHASES] = '{12, 12, 12, 10};
	localparam int PH_ADDPCT [PHASES] = '{60, 70, 65, 60};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // sentence_id[15:0], token_count[22:16], zero pad
	logic        s_axis_tuser = 1'b0; // cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // out_id[15:0], out_length[22:16], zero pad
	logic [2:0]  m_axis_tuser;        // status
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the bucket queues and registers
	logic [15:0] shadow_ids [0:TOP_LEN][0:SLOTS-1];
	int          shadow_head [0:TOP_LEN];
	int          shadow_fill [0:TOP_LEN];
	logic [15:0] cur_budget;
	logic [6:0]  cur_max_len;

	batch_result_t pending_results [$];
	int            fail_count = 0;
	int            src_idle_pct = 35;
	int            snk_idle_pct = 51;
	bit            long_hold_req = 1'b0;

	length_bucketed_batch_former uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAIL length_bucketed_batch_former");
		$finish;
	end

	function automatic void note_fail(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	// append one expected result at the tail
	function automatic void enqueue_result(input batch_result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void predict_bucket_outcome(input logic op, input logic [15:0] id,
	                                               input logic [6:0] len);
		batch_result_t r;
		int taken;
		bit halt;
		r = '{ST_ADDED, 16'h0, 7'd0, 1'b1};
		if (op == CMD_OP_ADD) begin
			if (len > cur_max_len || len > TOP_LEN) begin
				r.status = ST_REJECT;
			end else if (shadow_fill[len] >= SLOTS) begin
				r.status = ST_FULL;
			end else begin
				shadow_ids[len][(shadow_head[len] + shadow_fill[len]) % SLOTS] = id;
				shadow_fill[len]++;
			end
			enqueue_result(r);
			return;
		end
		taken = 0;
		halt = 1'b0;
		for (int l = 0; l <= TOP_LEN && !halt; l++) begin
			while (shadow_fill[l] > 0 && !halt) begin
				if (taken >= BATCH_CAP || (taken + 1) * l > int'(cur_budget)) begin
					halt = 1'b1;
				end else begin
					r = '{ST_MEMBER, shadow_ids[l][shadow_head[l]], 7'(l), 1'b0};
					enqueue_result(r);
					shadow_head[l] = (shadow_head[l] + 1) % SLOTS;
					shadow_fill[l]--;
					taken++;
				end
			end
		end
		if (taken == 0) begin
			r = '{ST_NO_BATCH, 16'h0, 7'd0, 1'b1};
		end else begin
			r = pending_results.pop_back();
			r.last = 1'b1;
		end
		enqueue_result(r);
	endfunction

	task automatic compare_result();
		batch_result_t want;
		if (pending_results.size() == 0) begin
			note_fail($sformatf("unexpected result: status %0d id %h len %0d last %b",
				m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[22:16], m_axis_tlast));
			return;
		end
		want = pending_results.pop_front();
		if (m_axis_tuser !== want.status || m_axis_tdata[15:0] !== want.id ||
		    m_axis_tdata[22:16] !== want.len || m_axis_tlast !== want.last)
			note_fail($sformatf(
				"mismatch: expected status %0d id %h len %0d last %b, got %0d %h %0d %b",
				want.status, want.id, want.len, want.last, m_axis_tuser,
				m_axis_tdata[15:0], m_axis_tdata[22:16], m_axis_tlast));
	endtask

	// result side: random back-pressure, plus one long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
				compare_result();
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic send_req(input logic op, input logic [15:0] id, input logic [6:0] len,
	                        input logic fixed, input status_t fixed_st);
		batch_result_t typed;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {1'b0, len, id};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		predict_bucket_outcome(op, id, len);
		// rows with a known answer replace the predicted one
		if (fixed) begin
			void'(pending_results.pop_back());
			typed = '{fixed_st, 16'h0, 7'd0, 1'b1};
			enqueue_result(typed);
		end
	endtask

	task automatic drain_results(input int settle);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [15:0] value);
		logic [31:0] want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (sel == REG_BUDGET)
			cur_budget = value;
		else
			cur_max_len = value[6:0];
		want = (sel == REG_BUDGET) ? {16'h0, cur_budget} : {25'h0, cur_max_len};
		// read back straight after the write
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			note_fail($sformatf("register %0d reads %h, expected %h", sel, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_idle(input int mode);
		src_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 51 : 0;
		snk_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 35 : 0;
	endtask

	initial begin
		plan_row_t   row;
		logic        op;
		logic [6:0]  len;
		logic [15:0] rid;
		for (int l = 0; l <= TOP_LEN; l++) begin
			shadow_head[l] = 0;
			shadow_fill[l] = 0;
			for (int s = 0; s < SLOTS; s++)
				shadow_ids[l][s] = '0;
		end
		cur_budget = BUDGET_RST;
		cur_max_len = MAX_LEN_RST;
		set_idle(0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			row = PLAN[r];
			if (row.kind == ROW_CFG) begin
				drain_results(10);
				write_reg(row.regsel, row.val);
			end else begin
				for (int k = 0; k < row.reps; k++)
					send_req((row.kind == ROW_CUT) ? CMD_OP_CUT : CMD_OP_ADD,
						row.val + 16'(k), row.len, row.chk, row.st);
			end
		end

		// fill five short buckets past the batch cap while results back up
		drain_results(10);
		write_reg(REG_BUDGET, 16'hFFFF);
		write_reg(REG_MAX_LEN, 16'd64);
		long_hold_req = 1'b1;
		for (int k = 0; k < 70; k++) begin
			rid = 16'($urandom);
			send_req(CMD_OP_ADD, rid, 7'(k % 5), 1'b0, ST_ADDED);
		end
		send_req(CMD_OP_CUT, 16'($urandom), 7'($urandom_range(0, 127)), 1'b0, ST_ADDED);
		send_req(CMD_OP_CUT, 16'h0, 7'd0, 1'b0, ST_ADDED);

		for (int p = 0; p < PHASES; p++) begin
			drain_results(10);
			write_reg(REG_BUDGET, 16'(PH_BUDGET[p]));
			write_reg(REG_MAX_LEN, 16'(PH_MAXLEN[p]));
			set_idle(PH_MODE[p]);
			for (int k = 0; k < PH_ITEMS[p]; k++) begin
				op = ($urandom_range(99) < PH_ADDPCT[p]) ? CMD_OP_ADD : CMD_OP_CUT;
				rid = 16'($urandom);
				if ($urandom_range(99) < 75)
					len = 7'($urandom_range(0, int'(cur_max_len)));
				else
					len = 7'($urandom_range(0, TOP_LEN));
				send_req(op, rid, len, 1'b0, ST_ADDED);
			end
		end

		drain_results(50);
		if (fail_count == 0)
			$display("PASS length_bucketed_batch_former");
		else
			$display("FAIL length_bucketed_batch_former");
		$finish;
	end

endmodule

@@ length_bucketed_batch_former.f @@
+incdir+design
design/lbbf_pkg.sv
design/lbbf_front.sv
design/lbbf_queue.sv
design/lbbf_engine.sv
design/length_bucketed_batch_former.sv
sim/tb_length_bucketed_batch_former.sv
